// ===== src/hmf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hmf_pkg;

    localparam int unsigned LENGTH_WIDTH_DEF = 32;
    localparam int unsigned PREFIX_LEN_DEF   = 16;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned POS_W     = 5;
    localparam int unsigned OUT_LEN_W = 32;

    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [POS_W-1:0]  POS_MAX    = 5'd31;

    typedef enum logic [1:0] {
        KIND_HEADER   = 2'd0,
        KIND_LINE_END = 2'd1,
        KIND_HDR_END  = 2'd2,
        KIND_BODY     = 2'd3
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0]    out_byte;
        t_kind                byte_kind;
        logic                 message_end;
        logic [OUT_LEN_W-1:0] content_length;
        logic                 length_error;
    } t_result;

    typedef struct packed {
        logic in_body;
        logic length_zero;
    } t_core_status;

    // Characters of "Content-Length: ", padded with spaces.
    function automatic logic [BYTE_W-1:0] hmf_prefix_char(input logic [POS_W-1:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            5'd0:    c = 8'h43;
            5'd1:    c = 8'h6F;
            5'd2:    c = 8'h6E;
            5'd3:    c = 8'h74;
            5'd4:    c = 8'h65;
            5'd5:    c = 8'h6E;
            5'd6:    c = 8'h74;
            5'd7:    c = 8'h2D;
            5'd8:    c = 8'h4C;
            5'd9:    c = 8'h65;
            5'd10:   c = 8'h6E;
            5'd11:   c = 8'h67;
            5'd12:   c = 8'h74;
            5'd13:   c = 8'h68;
            5'd14:   c = 8'h3A;
            default: c = CHAR_SPACE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/hmf_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hmf_in_stage
    import hmf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    input  wire logic [BYTE_W-1:0] i_s_tdata,
    input  wire logic              i_advance,
    output logic                   o_s_tready,
    output logic                   o_valid,
    output logic [BYTE_W-1:0]      o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    assign o_s_tready = !r_valid || i_advance;
    assign o_valid    = r_valid;
    assign o_byte     = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_byte <= i_s_tdata;
        end
    end

endmodule

`default_nettype wire

// ===== src/hmf_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hmf_core
    import hmf_pkg::*;
#(
    parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEF,
    parameter int unsigned PREFIX_LEN   = PREFIX_LEN_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire logic [BYTE_W-1:0] i_byte,
    output t_result                o_result,
    output t_core_status           o_status
);

    localparam int unsigned LEN_EXT_W = LENGTH_WIDTH + 4;
    localparam int unsigned OUT_EXT_W =
        (LENGTH_WIDTH > OUT_LEN_W) ? LENGTH_WIDTH : OUT_LEN_W;
    localparam logic [POS_W-1:0] PREFIX_END = POS_W'(PREFIX_LEN);

    logic                    r_in_body;
    logic [POS_W-1:0]        r_line_pos;
    logic                    r_prefix_match;
    logic                    r_began_cr;
    logic [LENGTH_WIDTH-1:0] r_length;
    logic                    r_bad_length;

    logic                    n_in_body;
    logic [POS_W-1:0]        n_line_pos;
    logic                    n_prefix_match;
    logic                    n_began_cr;
    logic [LENGTH_WIDTH-1:0] n_length;
    logic                    n_bad_length;

    logic [LENGTH_WIDTH-1:0] upd_length;
    logic                    upd_bad;
    logic                    done;
    t_kind                   kind;
    logic                    is_digit;
    logic [BYTE_W-1:0]       digit_full;
    logic [LEN_EXT_W-1:0]    length_ext;
    logic [LEN_EXT_W-1:0]    product;
    logic [LENGTH_WIDTH-1:0] value_next;
    logic [OUT_EXT_W-1:0]    length_out;

    assign is_digit   = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
    assign digit_full = i_byte - CHAR_ZERO;
    assign length_ext = LEN_EXT_W'(r_length);
    assign product    = (length_ext << 3) + (length_ext << 1) + LEN_EXT_W'(digit_full[3:0]);
    assign value_next = (product[LEN_EXT_W-1:LENGTH_WIDTH] != 4'd0) ?
                        {LENGTH_WIDTH{1'b1}} : product[LENGTH_WIDTH-1:0];

    always_comb begin
        n_in_body      = r_in_body;
        n_line_pos     = r_line_pos;
        n_prefix_match = r_prefix_match;
        n_began_cr     = r_began_cr;
        upd_length     = r_length;
        upd_bad        = r_bad_length;
        done           = 1'b0;
        kind           = KIND_HEADER;

        if (r_in_body) begin
            kind = KIND_BODY;
            if (r_length != '0) begin
                upd_length = r_length - 1'b1;
            end
            done = (upd_length == '0);
        end else if (i_byte == CHAR_LF) begin
            if (r_began_cr && (r_line_pos == 5'd1)) begin
                kind = KIND_HDR_END;
                if (r_length == '0) begin
                    done = 1'b1;
                end else begin
                    n_in_body = 1'b1;
                end
            end else begin
                kind = KIND_LINE_END;
            end
            n_line_pos     = '0;
            n_prefix_match = 1'b1;
            n_began_cr     = 1'b0;
        end else begin
            kind = KIND_HEADER;
            if ((r_line_pos == '0) && (i_byte == CHAR_CR)) begin
                n_began_cr = 1'b1;
            end
            if (r_line_pos < PREFIX_END) begin
                if (i_byte != hmf_prefix_char(r_line_pos)) begin
                    n_prefix_match = 1'b0;
                end
            end else if (r_prefix_match && (i_byte != CHAR_CR)) begin
                if (is_digit) begin
                    upd_length = value_next;
                end else begin
                    upd_bad = 1'b1;
                end
            end
            if (r_line_pos < POS_MAX) begin
                n_line_pos = r_line_pos + 1'b1;
            end
        end

        n_length     = upd_length;
        n_bad_length = upd_bad;
        if (done) begin
            n_in_body      = 1'b0;
            n_line_pos     = '0;
            n_prefix_match = 1'b1;
            n_began_cr     = 1'b0;
            n_length       = '0;
            n_bad_length   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_body      <= 1'b0;
            r_line_pos     <= '0;
            r_prefix_match <= 1'b1;
            r_began_cr     <= 1'b0;
            r_length       <= '0;
            r_bad_length   <= 1'b0;
        end else if (i_advance) begin
            r_in_body      <= n_in_body;
            r_line_pos     <= n_line_pos;
            r_prefix_match <= n_prefix_match;
            r_began_cr     <= n_began_cr;
            r_length       <= n_length;
            r_bad_length   <= n_bad_length;
        end
    end

    assign length_out = OUT_EXT_W'(upd_length);

    always_comb begin
        o_result.out_byte       = i_byte;
        o_result.byte_kind      = kind;
        o_result.message_end    = done;
        o_result.content_length = length_out[OUT_LEN_W-1:0];
        o_result.length_error   = upd_bad;
    end

    assign o_status.in_body     = r_in_body;
    assign o_status.length_zero = (r_length == '0);

endmodule

`default_nettype wire

// ===== src/hmf_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hmf_out_stage
    import hmf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_m_tready,
    output logic         o_can_load,
    output logic         o_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_m_tready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// ===== src/http_message_framer_unit.sv =====
// Frames one HTTP/1 message from a byte stream using its Content-Length header. Each byte
// comes out again tagged as a header byte, a header line end, the end of the headers, or a
// body byte, together with the length parsed so far (a countdown of body bytes left once the
// body starts) and a sticky flag for a malformed length value; tlast marks the byte that
// completes the message, after which all framing state clears. The block takes one byte per
// cycle while the downstream side does not stall; each byte passes from the input register
// through the per-byte state update into the result register. A downstream stall holds both
// registers only while the result register is full.
`timescale 1ns / 1ps
`default_nettype none

module http_message_framer_unit
    import hmf_pkg::*;
#(
    parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEF,
    parameter int unsigned PREFIX_LEN   = PREFIX_LEN_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata,   // [7:0] out_byte, [39:8] content_length,
                                          // [40] length_error, [47:41] zero
    output logic [1:0]       o_m_tuser,   // [1:0] byte_kind
    output logic             o_m_tlast    // message_end
);

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              can_load;
    logic              advance;
    t_result           core_result;
    t_result           out_result;
    t_core_status      core_status;

    assign advance = in_valid && can_load;

    hmf_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_advance  (advance),
        .o_s_tready (o_s_tready),
        .o_valid    (in_valid),
        .o_byte     (in_byte)
    );

    hmf_core #(
        .LENGTH_WIDTH (LENGTH_WIDTH),
        .PREFIX_LEN   (PREFIX_LEN)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (in_byte),
        .o_result  (core_result),
        .o_status  (core_status)
    );

    hmf_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (core_result),
        .i_m_tready (i_m_tready),
        .o_can_load (can_load),
        .o_valid    (o_m_tvalid),
        .o_result   (out_result)
    );

    assign o_m_tdata = {7'd0, out_result.length_error, out_result.content_length,
                        out_result.out_byte};
    assign o_m_tuser = out_result.byte_kind;
    assign o_m_tlast = out_result.message_end;

`ifndef SYNTHESIS
    a_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tuser == KIND_BODY || o_m_tuser == KIND_HDR_END))
        else $error("Message end on a header byte or line end.");

    a_body_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_status.in_body |-> !core_status.length_zero)
        else $error("Body phase with no bytes left.");

    a_advance_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_m_tvalid)
        else $error("Processed byte did not reach the result register.");
`endif

endmodule

`default_nettype wire
